/* hw/rtl/mlfd_pkg.sv */
`default_nettype none

package mlfd_pkg;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_LEN   = 2'd1,
      PH_DATA  = 2'd2,
      PH_END   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_DONE      = 2'd1,
      KIND_BAD_START = 2'd2,
      KIND_BAD_END   = 2'd3
   } kind_type;

   localparam logic CSR_START_MARKER = 1'b0;
   localparam logic CSR_END_MARKER   = 1'b1;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic        payload_last;
      logic [15:0] frame_length;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/mlfd_parser.sv */
`default_nettype none

module mlfd_parser (
   input  wire               clock,
   input  wire               reset,
   input  wire               step,
   input  wire [7:0]         rx_byte,
   input  wire [15:0]        start_marker,
   input  wire [15:0]        end_marker,
   output logic              emit,
   output mlfd_pkg::rsp_type result
);

   mlfd_pkg::phase_type phase_ff, phase_in;
   logic        odd_held_ff, odd_held_in;
   logic [7:0]  high_byte_ff, high_byte_in;
   logic [15:0] frame_len_ff, frame_len_in;
   logic [15:0] bytes_seen_ff, bytes_seen_in;

   logic [15:0] word;
   logic [15:0] next_count;
   logic        last;

   assign word       = {high_byte_ff, rx_byte};
   assign next_count = bytes_seen_ff + 16'd1;
   assign last       = (next_count >= frame_len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= mlfd_pkg::PH_START;
         odd_held_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         odd_held_ff <= odd_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         high_byte_ff  <= high_byte_in;
         frame_len_ff  <= frame_len_in;
         bytes_seen_ff <= bytes_seen_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      odd_held_in    = odd_held_ff;
      high_byte_in   = high_byte_ff;
      frame_len_in   = frame_len_ff;
      bytes_seen_in  = bytes_seen_ff;
      emit           = 1'b0;
      result         = '0;
      result.kind    = mlfd_pkg::KIND_DATA;
      if (phase_ff == mlfd_pkg::PH_DATA) begin
         // payload bytes pass straight through, no pairing
         bytes_seen_in       = next_count;
         emit                = 1'b1;
         result.payload_byte = rx_byte;
         result.payload_last = last;
         if (last) begin
            phase_in = mlfd_pkg::PH_END;
         end
      end else if (!odd_held_ff) begin
         high_byte_in = rx_byte;
         odd_held_in  = 1'b1;
      end else begin
         odd_held_in = 1'b0;
         unique case (phase_ff)
            mlfd_pkg::PH_START: begin
               if (word != start_marker) begin
                  emit        = 1'b1;
                  result.kind = mlfd_pkg::KIND_BAD_START;
               end else begin
                  phase_in = mlfd_pkg::PH_LEN;
               end
            end
            mlfd_pkg::PH_LEN: begin
               frame_len_in  = word;
               bytes_seen_in = '0;
               phase_in      = (word == 16'd0) ? mlfd_pkg::PH_END : mlfd_pkg::PH_DATA;
            end
            default: begin
               emit = 1'b1;
               if (word != end_marker) begin
                  result.kind = mlfd_pkg::KIND_BAD_END;
               end else begin
                  phase_in            = mlfd_pkg::PH_START;
                  result.kind         = mlfd_pkg::KIND_DONE;
                  result.frame_length = frame_len_ff;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/mlfd_rsp_reg.sv */
`default_nettype none

module mlfd_rsp_reg (
   input  wire               clock,
   input  wire               reset,
   input  wire               load,
   input  wire mlfd_pkg::rsp_type load_data,
   output logic              free,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output mlfd_pkg::rsp_type rsp_data
);

   logic              valid_ff, valid_in;
   mlfd_pkg::rsp_type data_ff;

   // slot can take a new transaction when empty or being drained this cycle
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

/* hw/rtl/magic_length_frame_deframer.sv */
// Byte-stream deframer for frames laid out as: start marker (16 bits,
// big-endian), payload length (16 bits), payload bytes, end marker.
// req_ carries one received byte per transaction; rsp_ returns zero or one
// result per byte: a payload byte (with payload_last on the final one), a
// frame-done report with its length, or a bad start / bad end marker report.
// Marker and length words are taken from aligned byte pairs; a bad marker
// keeps the parser in the same phase so the next pair is tried.
// csr_ writes the expected start marker (index 0) and end marker (index 1);
// it is always ready. Write it only while no byte is in flight.
// Each result passes through the input register and the result register
// before it is on rsp_. Throughput: one byte per cycle while rsp_ready
// drains the result register, set by the single input register feeding
// the parser and the single result register.
// Reset returns the parser to awaiting a start marker, clears both markers
// to zero and empties the pipeline.
// When rsp_ready is low with a result held, the byte in the input register
// waits and req_ready drops; nothing is lost or reordered.
`default_nettype none

module magic_length_frame_deframer (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_last,
   output logic [15:0] rsp_frame_length,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [15:0] csr_data
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic [15:0] start_marker_ff;
   logic [15:0] end_marker_ff;

   logic              advance;
   logic              emit;
   logic              free;
   mlfd_pkg::rsp_type result;
   mlfd_pkg::rsp_type rsp_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= '0;
         end_marker_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            mlfd_pkg::CSR_START_MARKER: start_marker_ff <= csr_data;
            mlfd_pkg::CSR_END_MARKER:   end_marker_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // advance the held byte once the result slot can take its outcome
   assign advance   = in_valid_ff && free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   mlfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .rx_byte      (in_byte_ff),
      .start_marker (start_marker_ff),
      .end_marker   (end_marker_ff),
      .emit         (emit),
      .result       (result)
   );

   mlfd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .load_data (result),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_payload_byte = rsp_data.payload_byte;
   assign rsp_payload_last = rsp_data.payload_last;
   assign rsp_frame_length = rsp_data.frame_length;

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_last;
   logic [15:0] rsp_frame_length;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = mlfd_pkg::CSR_START_MARKER;
   logic [15:0] csr_data = 16'h0000;

   int unsigned send_idle_pct = 34;
   int unsigned recv_idle_pct = 54;
   bit          hold_req = 1'b0;
   logic        rx_hold = 1'b0;

   function automatic mlfd_pkg::rsp_type make_rsp(mlfd_pkg::kind_type k, logic [7:0] b,
                                                  logic l, logic [15:0] n);
      mlfd_pkg::rsp_type r;
      r.kind = k;
      r.payload_byte = b;
      r.payload_last = l;
      r.frame_length = n;
      return r;
   endfunction

   class frame_scoreboard_type;
      logic [15:0]         start_word;
      logic [15:0]         end_word;
      mlfd_pkg::phase_type phase;
      bit                  pair_open;
      logic [7:0]          high_byte;
      logic [15:0]         length_word;
      logic [15:0]         payload_count;
      mlfd_pkg::rsp_type   expected_q[$];
      int unsigned         errors;
      int unsigned         bytes_noted;
      int unsigned         payload_results;
      int unsigned         frames_done;
      int unsigned         bad_starts;
      int unsigned         bad_ends;

      function new();
         start_word = '0;
         end_word = '0;
         phase = mlfd_pkg::PH_START;
         pair_open = 1'b0;
         high_byte = '0;
         length_word = '0;
         payload_count = '0;
         errors = 0;
         bytes_noted = 0;
         payload_results = 0;
         frames_done = 0;
         bad_starts = 0;
         bad_ends = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void queue_result(mlfd_pkg::rsp_type r);
         expected_q.insert(expected_q.size(), r);
      endfunction

      // advance the parser by one accepted byte and queue what it produces
      function void note_byte(logic [7:0] b);
         logic [15:0] word;
         bytes_noted++;
         if (phase == mlfd_pkg::PH_DATA) begin
            payload_count++;
            queue_result(make_rsp(mlfd_pkg::KIND_DATA, b, payload_count >= length_word, '0));
            if (payload_count >= length_word) phase = mlfd_pkg::PH_END;
            return;
         end
         if (!pair_open) begin
            high_byte = b;
            pair_open = 1'b1;
            return;
         end
         pair_open = 1'b0;
         word = {high_byte, b};
         high_byte = '0;
         case (phase)
            mlfd_pkg::PH_START: begin
               if (word != start_word)
                  queue_result(make_rsp(mlfd_pkg::KIND_BAD_START, '0, 1'b0, '0));
               else phase = mlfd_pkg::PH_LEN;
            end
            mlfd_pkg::PH_LEN: begin
               length_word = word;
               payload_count = '0;
               phase = (word == 16'h0000) ? mlfd_pkg::PH_END : mlfd_pkg::PH_DATA;
            end
            default: begin
               if (word != end_word) begin
                  queue_result(make_rsp(mlfd_pkg::KIND_BAD_END, '0, 1'b0, '0));
               end else begin
                  phase = mlfd_pkg::PH_START;
                  queue_result(make_rsp(mlfd_pkg::KIND_DONE, '0, 1'b0, length_word));
               end
            end
         endcase
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(mlfd_pkg::rsp_type got);
         mlfd_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result kind %0d with nothing pending", got.kind));
            return;
         end
         want = expected_q.pop_front();
         if (got.kind != want.kind)
            report($sformatf("kind %0d, want %0d", got.kind, want.kind));
         if (got.payload_byte != want.payload_byte)
            report($sformatf("payload_byte %h, want %h", got.payload_byte, want.payload_byte));
         if (got.payload_last != want.payload_last)
            report($sformatf("payload_last %b, want %b", got.payload_last, want.payload_last));
         if (got.frame_length != want.frame_length)
            report($sformatf("frame_length %0d, want %0d", got.frame_length, want.frame_length));
         case (want.kind)
            mlfd_pkg::KIND_DATA: payload_results++;
            mlfd_pkg::KIND_DONE: frames_done++;
            mlfd_pkg::KIND_BAD_START: bad_starts++;
            default: bad_ends++;
         endcase
      endtask
   endclass

   frame_scoreboard_type sb = new();

   magic_length_frame_deframer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_last (rsp_payload_last),
      .rsp_frame_length (rsp_frame_length),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // long receiver hold-off, timed here so the sender keeps pushing meanwhile
   initial begin
      forever begin
         wait (hold_req);
         hold_req = 1'b0;
         rx_hold <= 1'b1;
         repeat (300) @(posedge clock);
         rx_hold <= 1'b0;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(make_rsp(mlfd_pkg::kind_type'(rsp_kind), rsp_payload_byte,
                                  rsp_payload_last, rsp_frame_length));
   end

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
   endtask

   task automatic send_word(input logic [15:0] w);
      send_byte(w[15:8]);
      send_byte(w[7:0]);
   endtask

   function automatic logic [15:0] other_word(logic [15:0] m);
      return m ^ 16'($urandom_range(65535, 1));
   endfunction

   task automatic send_frame(input logic [15:0] len, input int unsigned bad_start_n,
                             input int unsigned bad_end_n);
      repeat (bad_start_n) send_word(other_word(sb.start_word));
      send_word(sb.start_word);
      send_word(len);
      repeat (len) send_byte(8'($urandom));
      repeat (bad_end_n) send_word(other_word(sb.end_word));
      send_word(sb.end_word);
   endtask

   // bring the parser back to an aligned start-marker search
   task automatic resync();
      while (sb.pair_open || sb.phase != mlfd_pkg::PH_START) begin
         if (sb.pair_open || sb.phase == mlfd_pkg::PH_DATA) send_byte(8'($urandom));
         else if (sb.phase == mlfd_pkg::PH_LEN) send_word(16'h0000);
         else send_word(sb.end_word);
      end
   endtask

   task automatic random_sequence();
      int unsigned pick;
      logic [15:0] len;
      pick = $urandom_range(99);
      len = ($urandom_range(99) < 5) ? 16'($urandom_range(300, 13)) : 16'($urandom_range(12, 0));
      if (pick < 8) begin
         repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
      end else if (pick < 14) begin
         // cut the frame short; whatever follows lands mid-frame
         resync();
         send_word(sb.start_word);
         send_word(len);
         repeat ($urandom_range(3, 0)) send_byte(8'($urandom));
      end else if (pick < 18) begin
         send_frame(len, 0, 0);
      end else begin
         resync();
         send_frame(len, (pick < 30) ? $urandom_range(2, 1) : 0,
                    (pick >= 30 && pick < 42) ? $urandom_range(2, 1) : 0);
      end
   endtask

   task automatic run_random(input int unsigned target);
      int unsigned stop_at;
      stop_at = sb.bytes_noted + target;
      while (sb.bytes_noted < stop_at) random_sequence();
   endtask

   // drop valid and wait for all results, then for the pipeline to empty
   task automatic settle();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_markers(input logic [15:0] s, input logic [15:0] e);
      csr_valid <= 1'b1;
      csr_index <= mlfd_pkg::CSR_START_MARKER;
      csr_data <= s;
      do @(posedge clock); while (!csr_ready);
      sb.start_word = s;
      csr_index <= mlfd_pkg::CSR_END_MARKER;
      csr_data <= e;
      do @(posedge clock); while (!csr_ready);
      sb.end_word = e;
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // markers still at reset: one-byte frame carrying 0xff
      send_word(16'h0000);
      send_word(16'h0001);
      send_byte(8'hFF);
      send_word(16'h0000);
      settle();

      // all-ones markers: bad start, zero length, bad end, then good end
      write_markers(16'hFFFF, 16'hFFFF);
      send_word(16'h1234);
      send_word(16'hFFFF);
      send_word(16'h0000);
      send_word(16'h0000);
      send_word(16'hFFFF);
      settle();

      // change the end marker while the parser waits for it
      write_markers(16'hA55A, 16'h0000);
      send_word(16'hA55A);
      send_word(16'h0002);
      send_byte(8'h00);
      send_byte(8'h7E);
      settle();
      write_markers(16'hA55A, 16'h5AA5);
      send_word(16'h5AA5);
      settle();

      write_markers(16'($urandom), 16'($urandom));
      run_random(250);
      hold_req = 1'b1;
      resync();
      send_frame(16'd40, 0, 0);
      settle();
      run_random(250);
      settle();

      send_idle_pct = 54;
      recv_idle_pct = 34;
      write_markers(16'h0000, 16'hFFFF);
      run_random(500);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_markers(16'($urandom), 16'($urandom));
      run_random(450);
      resync();
      send_frame(16'd24, 0, 1);
      // largest length word, cut short after a few payload bytes
      send_word(sb.start_word);
      send_word(16'hFFFF);
      repeat (16) send_byte(8'($urandom));
      settle();

      if (sb.pending() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      $display("covered %0d bytes: %0d payload bytes, %0d complete frames",
               sb.bytes_noted, sb.payload_results, sb.frames_done);
      $display("marker errors seen: %0d bad start, %0d bad end", sb.bad_starts, sb.bad_ends);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
